>>> rtl/core/quicksort_lomuto_engine_assert.svh
// Assertion macros shared by the quicksort engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH
`define QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define QSL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qsl assertion failed");
// next-cycle implication
`define QSL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qsl assertion failed");
`else
`define QSL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define QSL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/qsl_pkg.sv
// Shared constants and types of the quicksort engine.
// No dependencies; used by the interfaces, the partition unit, the engine and the bench.
package qsl_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int STORE_DEPTH = 64;
   localparam int MAX_ITEMS   = 64;
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = 7;
   localparam int SP_IDX_W    = 6;
   localparam int ENTRY_W     = 2 * IDX_W;

   localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_ITEMS);
   localparam logic [SP_W-1:0]  STACK_LIMIT = SP_W'(STACK_DEPTH);

   // one access to the element memory
   typedef struct packed {
      logic                     we;
      logic [IDX_W-1:0]         waddr;
      logic signed [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]         raddr;
   } mem_req_type;

   // one access to the range stack memory
   typedef struct packed {
      logic                  we;
      logic [SP_IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0]    wdata;
      logic [SP_IDX_W-1:0]   raddr;
   } stk_req_type;

   // partition request from the sequencer
   typedef struct packed {
      logic             start;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } part_cmd_type;

   // partition completion
   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] pidx;
   } part_sts_type;

endpackage

>>> rtl/core/qsl_if.sv
// Valid/ready channel interfaces for the quicksort engine: input beats and result beats.
// Depends on qsl_pkg for field widths.
interface qsl_req_if;
   import qsl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface qsl_rsp_if;
   import qsl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic [IDX_W-1:0]         position;
   logic                     last_result;
   logic                     overflow;

   modport source (output valid, output sorted_value, output position,
                   output last_result, output overflow, input ready);
   modport sink   (input valid, input sorted_value, input position,
                   input last_result, input overflow, output ready);
endinterface

>>> rtl/core/qsl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
module qsl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, write data forwarded on address match
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/qsl_partition.sv
// Lomuto partition unit: walks one index range of the element memory,
// swapping smaller elements forward, then places the pivot. Depends on qsl_pkg.
module qsl_partition (
   input  logic                             clock,
   input  logic                             reset,
   input  qsl_pkg::part_cmd_type            cmd,
   output qsl_pkg::part_sts_type            sts,
   output qsl_pkg::mem_req_type             mem_req,
   input  logic signed [qsl_pkg::DATA_W-1:0] mem_rdata
);
   import qsl_pkg::*;
   `include "quicksort_lomuto_engine_assert.svh"

   typedef enum logic [2:0] {
      P_IDLE, P_RDPIV, P_PIV, P_CMP, P_SWAP1, P_SWAP2, P_FIN1, P_FIN2
   } part_state_type;

   part_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]         next_ff, next_in;
   logic signed [DATA_W-1:0] pivot_ff, pivot_in;
   logic signed [DATA_W-1:0] valk_ff, valk_in;
   logic signed [DATA_W-1:0] tmp_ff, tmp_in;
   logic [IDX_W-1:0]         next_new;
   logic                     below;
   logic                     at_end;

   assign below  = mem_rdata < pivot_ff;
   assign at_end = (k_ff + IDX_W'(1)) == hi_ff;

   // next-state and memory access
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      next_in  = next_ff;
      pivot_in = pivot_ff;
      valk_in  = valk_ff;
      tmp_in   = tmp_ff;
      next_new = next_ff;
      mem_req  = '0;
      sts      = '0;
      case (state_ff)
         P_IDLE: begin
            if (cmd.start) begin
               lo_in    = cmd.lo;
               hi_in    = cmd.hi;
               state_in = P_RDPIV;
            end
         end
         P_RDPIV: begin
            mem_req.raddr = hi_ff;
            state_in      = P_PIV;
         end
         P_PIV: begin
            pivot_in      = mem_rdata;
            k_in          = lo_ff;
            next_in       = lo_ff;
            mem_req.raddr = lo_ff;
            state_in      = P_CMP;
         end
         P_CMP: begin
            valk_in = mem_rdata;
            if (below && (next_ff != k_ff)) begin
               // fetch the element to swap with
               mem_req.raddr = next_ff;
               state_in      = P_SWAP1;
            end else begin
               next_new = below ? next_ff + IDX_W'(1) : next_ff;
               next_in  = next_new;
               if (at_end) begin
                  mem_req.raddr = next_new;
                  state_in      = P_FIN1;
               end else begin
                  k_in          = k_ff + IDX_W'(1);
                  mem_req.raddr = k_ff + IDX_W'(1);
               end
            end
         end
         P_SWAP1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = next_ff;
            mem_req.wdata = valk_ff;
            tmp_in        = mem_rdata;
            state_in      = P_SWAP2;
         end
         P_SWAP2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = k_ff;
            mem_req.wdata = tmp_ff;
            next_new      = next_ff + IDX_W'(1);
            next_in       = next_new;
            if (at_end) begin
               mem_req.raddr = next_new;
               state_in      = P_FIN1;
            end else begin
               k_in          = k_ff + IDX_W'(1);
               mem_req.raddr = k_ff + IDX_W'(1);
               state_in      = P_CMP;
            end
         end
         P_FIN1: begin
            // pivot into its final slot
            mem_req.we    = 1'b1;
            mem_req.waddr = next_ff;
            mem_req.wdata = pivot_ff;
            tmp_in        = mem_rdata;
            state_in      = P_FIN2;
         end
         P_FIN2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = tmp_ff;
            sts.done      = 1'b1;
            sts.pidx      = next_ff;
            state_in      = P_IDLE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      k_ff     <= k_in;
      next_ff  <= next_in;
      pivot_ff <= pivot_in;
      valk_ff  <= valk_in;
      tmp_ff   <= tmp_in;
   end

   `QSL_ASSERT_IMPLIES(a_next_behind_scan, clock, reset, state_ff == P_CMP, next_ff <= k_ff)
   `QSL_ASSERT_IMPLIES(a_scan_below_pivot, clock, reset, state_ff == P_CMP, k_ff < hi_ff)
   `QSL_ASSERT_IMPLIES(a_start_when_idle, clock, reset, cmd.start, state_ff == P_IDLE)

endmodule

>>> rtl/core/quicksort_lomuto_engine.sv
// Quicksort engine (Lomuto partition). Input beats are loaded one per cycle into a
// 64-entry element memory until a beat marked last; beats beyond capacity are dropped
// and flagged. The batch is then sorted in place with an explicit range stack, during
// which no input is taken, and finally streamed out in ascending order; each result
// beat is read from the element memory and then loaded into the output register,
// and the next read waits until the output register frees up. Already ascending or
// all-equal data is the worst case, where each pivot splits off nothing. The partition
// unit compares one element per cycle through the single read port of the element
// memory, but stalls for each swap, which takes two writes through its write port.
// No memory clearing after reset.
module quicksort_lomuto_engine (
   input  logic            clock,
   input  logic            reset,
   qsl_req_if.sink         req_bus,
   qsl_rsp_if.source       rsp_bus
);
   import qsl_pkg::*;
   `include "quicksort_lomuto_engine_assert.svh"

   typedef enum logic [3:0] {
      S_LOAD, S_SORT_INIT, S_POP, S_RANGE, S_PART, S_PUSH_R, S_PUSH_L,
      S_EMIT_RD, S_EMIT_LD
   } seq_state_type;

   seq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     dropped_ff, dropped_in;
   logic [SP_W-1:0]          sp_ff, sp_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         p_ff, p_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   mem_req_type              top_mem, part_mem, elem_req;
   logic signed [DATA_W-1:0] elem_rdata;
   stk_req_type              stk_req;
   logic [ENTRY_W-1:0]       stk_rdata;
   part_cmd_type             part_cmd;
   part_sts_type             part_sts;
   logic [IDX_W-1:0]         ent_lo, ent_hi;
   logic                     emit_last;

   // element memory, owned by the partition unit while a range is split
   assign elem_req = (state_ff == S_PART) ? part_mem : top_mem;

   qsl_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_elem_ram (
      .clock (clock),
      .we    (elem_req.we),
      .waddr (elem_req.waddr),
      .wdata (elem_req.wdata),
      .raddr (elem_req.raddr),
      .rdata (elem_rdata)
   );

   qsl_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stk_req.we),
      .waddr (stk_req.waddr),
      .wdata (stk_req.wdata),
      .raddr (stk_req.raddr),
      .rdata (stk_rdata)
   );

   qsl_partition u_partition (
      .clock     (clock),
      .reset     (reset),
      .cmd       (part_cmd),
      .sts       (part_sts),
      .mem_req   (part_mem),
      .mem_rdata (elem_rdata)
   );

   assign ent_lo    = stk_rdata[ENTRY_W-1:IDX_W];
   assign ent_hi    = stk_rdata[IDX_W-1:0];
   assign emit_last = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;

   // ports
   assign req_bus.ready        = (state_ff == S_LOAD);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sorted_value = rsp_value_ff;
   assign rsp_bus.position     = rsp_pos_ff;
   assign rsp_bus.last_result  = rsp_last_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;

   // sequencer: load, range stack walk, emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      sp_in        = sp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      top_mem      = '0;
      stk_req      = '0;
      part_cmd     = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_bus.valid) begin
               if (count_ff < MAX_COUNT) begin
                  top_mem.we    = 1'b1;
                  top_mem.waddr = count_ff[IDX_W-1:0];
                  top_mem.wdata = req_bus.value;
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_bus.last_item) begin
                  state_in = S_SORT_INIT;
               end
            end
         end
         S_SORT_INIT: begin
            idx_in = '0;
            if (count_ff < CNT_W'(2)) begin
               sp_in    = '0;
               state_in = S_EMIT_RD;
            end else begin
               stk_req.we    = 1'b1;
               stk_req.waddr = '0;
               stk_req.wdata = {IDX_W'(0), count_ff[IDX_W-1:0] - IDX_W'(1)};
               sp_in         = SP_W'(1);
               state_in      = S_POP;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               stk_req.raddr = sp_ff[SP_IDX_W-1:0] - SP_IDX_W'(1);
               sp_in         = sp_ff - SP_W'(1);
               state_in      = S_RANGE;
            end
         end
         S_RANGE: begin
            lo_in = ent_lo;
            hi_in = ent_hi;
            if (ent_lo >= ent_hi) begin
               state_in = S_POP;
            end else begin
               part_cmd.start = 1'b1;
               part_cmd.lo    = ent_lo;
               part_cmd.hi    = ent_hi;
               state_in       = S_PART;
            end
         end
         S_PART: begin
            if (part_sts.done) begin
               p_in     = part_sts.pidx;
               state_in = S_PUSH_R;
            end
         end
         S_PUSH_R: begin
            // upper part first, so the lower part is popped next
            if ((({1'b0, p_ff} + CNT_W'(1)) < {1'b0, hi_ff}) && (sp_ff < STACK_LIMIT)) begin
               stk_req.we    = 1'b1;
               stk_req.waddr = sp_ff[SP_IDX_W-1:0];
               stk_req.wdata = {p_ff + IDX_W'(1), hi_ff};
               sp_in         = sp_ff + SP_W'(1);
            end
            state_in = S_PUSH_L;
         end
         S_PUSH_L: begin
            if (({1'b0, p_ff} > ({1'b0, lo_ff} + CNT_W'(1))) && (sp_ff < STACK_LIMIT)) begin
               stk_req.we    = 1'b1;
               stk_req.waddr = sp_ff[SP_IDX_W-1:0];
               stk_req.wdata = {lo_ff, p_ff - IDX_W'(1)};
               sp_in         = sp_ff + SP_W'(1);
            end
            state_in = S_POP;
         end
         S_EMIT_RD: begin
            // read only when the output register frees up this cycle
            if (!rsp_valid_ff || rsp_bus.ready) begin
               top_mem.raddr = idx_ff;
               state_in      = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = elem_rdata;
            rsp_pos_in   = idx_ff;
            rsp_last_in  = emit_last;
            rsp_ovf_in   = dropped_ff;
            if (emit_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
               sp_in      = '0;
               state_in   = S_LOAD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      p_ff         <= p_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   `QSL_ASSERT_IMPLIES(a_count_bounded, clock, reset, 1'b1, count_ff <= MAX_COUNT)
   `QSL_ASSERT_IMPLIES(a_stack_bounded, clock, reset, 1'b1, sp_ff <= STACK_LIMIT)
   `QSL_ASSERT_IMPLIES(a_done_in_part, clock, reset, part_sts.done, state_ff == S_PART)
   `QSL_ASSERT_NEXT(a_done_then_push, clock, reset, part_sts.done, state_ff == S_PUSH_R)

endmodule

>>> bench/tb_quicksort_lomuto_engine.sv
// Self-checking bench for quicksort_lomuto_engine: directed and random batches of
// signed values, predicted sorted beats compared in order with a scoreboard class.
// Depends on qsl_pkg, the qsl_req_if/qsl_rsp_if interfaces and the engine RTL.
module tb_quicksort_lomuto_engine;
   import qsl_pkg::*;

   localparam int BEAT_TARGET  = 460;
   localparam int QUIET_FROM   = 400;
   localparam int STALL_LIMIT  = 40000;
   localparam int DRAIN_CYCLES = 40;
   localparam int VALUE_MIN    = 32'sh8000_0000;
   localparam int VALUE_MAX    = 32'sh7fff_ffff;

   // one expected result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic [IDX_W-1:0]         position;
      logic                     last_result;
      logic                     overflow;
   } sorted_beat_type;

   // Predicts the sorted stream of each batch and checks the result beats in order.
   class sort_scoreboard;
      int              held [MAX_ITEMS];
      int              held_count;
      bit              dropped;
      sorted_beat_type pending [$];
      int              errors;
      int              batches;
      int              beats_checked;
      int              overflow_batches;

      // accepted input beat; the last one of a batch yields the sorted stream
      function void note_input(int value, bit last_item);
         int key;
         int j;
         sorted_beat_type beat;
         if (held_count < MAX_ITEMS) begin
            held[held_count] = value;
            held_count++;
         end else begin
            dropped = 1;
         end
         if (!last_item)
            return;
         // ascending order, signed compare
         for (int i = 1; i < held_count; i++) begin
            key = held[i];
            j = i - 1;
            while (j >= 0 && held[j] > key) begin
               held[j + 1] = held[j];
               j--;
            end
            held[j + 1] = key;
         end
         for (int i = 0; i < held_count; i++) begin
            beat.sorted_value = held[i];
            beat.position     = IDX_W'(i);
            beat.last_result  = (i == held_count - 1);
            beat.overflow     = dropped;
            pending.push_back(beat);
         end
         batches++;
         if (dropped)
            overflow_batches++;
         held_count = 0;
         dropped = 0;
      endfunction

      function void check_beat(sorted_beat_type seen);
         sorted_beat_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual value %0d pos %0d",
                     $time, seen.sorted_value, seen.position);
            errors++;
            return;
         end
         want = pending.pop_front();
         beats_checked++;
         if (seen.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d (pos %0d)",
                     $time, want.sorted_value, seen.sorted_value, want.position);
            errors++;
         end
         if (seen.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, seen.position);
            errors++;
         end
         if (seen.last_result !== want.last_result) begin
            $display("%0t: last_result expected %0b actual %0b (pos %0d)",
                     $time, want.last_result, seen.last_result, want.position);
            errors++;
         end
         if (seen.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b (pos %0d)",
                     $time, want.overflow, seen.overflow, want.position);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   qsl_req_if req_bus ();
   qsl_rsp_if rsp_bus ();

   quicksort_lomuto_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sort_scoreboard board = new;
   int batch_values [$];
   int beats_sent;
   bit quiet;
   int idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: random stall bursts, steady ready at the end
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // result monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_beat({rsp_bus.sorted_value, rsp_bus.position,
                              rsp_bus.last_result, rsp_bus.overflow});
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // one input beat, with an optional idle burst ahead of it
   task automatic send_beat(int value, bit last_item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.value     <= value;
      req_bus.last_item <= last_item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_input(value, last_item);
      beats_sent++;
      if (beats_sent >= QUIET_FROM)
         quiet = 1;
      @(negedge clock);
   endtask

   // sends batch_values, last flag on the final entry
   task automatic send_batch();
      for (int i = 0; i < batch_values.size(); i++)
         send_beat(batch_values[i], i == batch_values.size() - 1);
      batch_values.delete();
   endtask

   function automatic int pick_value(int mode);
      case (mode)
         0: return int'($urandom_range(0, 8)) - 4;   // dense duplicates
         1: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom());
      endcase
   endfunction

   initial begin
      int size;
      int mode;
      req_bus.valid     = 1'b0;
      req_bus.value     = '0;
      req_bus.last_item = 1'b0;
      reset             = 1'b1;
      quiet             = 0;
      beats_sent        = 0;
      idle_cycles       = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single-element batches at both extremes
      batch_values = '{VALUE_MAX};
      send_batch();
      batch_values = '{VALUE_MIN};
      send_batch();
      // two elements, descending
      batch_values = '{0, -1};
      send_batch();
      // mixed extremes
      batch_values = '{VALUE_MIN, VALUE_MAX, 0, -1, 1};
      send_batch();
      // all equal: nothing is strictly below the pivot
      batch_values = '{5, 5, 5, 5};
      send_batch();
      // already sorted and reverse sorted
      batch_values = '{1, 2, 3, 4, 5, 6};
      send_batch();
      batch_values = '{6, 5, 4, 3, 2, 1};
      send_batch();

      // random batches; the first one overruns the store so its last two beats are dropped
      size = 66;
      while (beats_sent < BEAT_TARGET) begin
         mode = $urandom_range(0, 5);
         for (int i = 0; i < size; i++)
            batch_values.push_back(pick_value(mode == 5 ? $urandom_range(0, 2) : mode));
         send_batch();
         case ($urandom_range(0, 19))
            0:       size = MAX_ITEMS;
            1:       size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            2, 3:    size = $urandom_range(17, MAX_ITEMS - 1);
            default: size = $urandom_range(1, 16);
         endcase
         if (quiet && size > 16)
            size = $urandom_range(1, 16);
      end

      // no more beats: release valid so the last one is not taken again
      req_bus.valid <= 1'b0;

      // drain
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d input beats in %0d batches, %0d of them overrunning the store",
               beats_sent, board.batches, board.overflow_batches);
      $display("tb: %0d sorted beats checked, %0d mismatches",
               board.beats_checked, board.errors);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/qsl_pkg.sv
rtl/core/qsl_if.sv
rtl/core/qsl_ram.sv
rtl/core/qsl_partition.sv
rtl/core/quicksort_lomuto_engine.sv
bench/tb_quicksort_lomuto_engine.sv
